[hw/rtl/dcmf_pkg.sv]
package dcmf_pkg;

  // Field and register widths
  localparam int PIX_W   = 8;
  localparam int DIM_W   = 12;
  localparam int RAD_W   = 4;
  localparam int OUT_W   = 11;
  localparam int ROW_W   = 13;
  localparam int LIM_W   = 6;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  // Register reset values
  localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [RAD_W-1:0] RADIUS_RST = 4'd7;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  // Per-token tags that ride along the pipeline
  typedef struct packed {
    logic             emit;
    logic             last;
    logic             done;
    logic [LIM_W-1:0] hlim;
    logic [OUT_W-1:0] orow;
    logic [OUT_W-1:0] ocol;
  } meta_t;

  // One queued result
  typedef struct packed {
    logic [PIX_W-1:0] dark;
    logic [OUT_W-1:0] orow;
    logic [OUT_W-1:0] ocol;
    logic             last;
    logic             done;
  } res_t;

  function automatic logic [PIX_W-1:0] min8(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

[hw/rtl/dark_channel_min_filter.sv]
// Path to out_valid: the line cells, the horizontal-window registers, then the result queue.
// Throughput: one transaction per cycle while the result queue has room; the last pixel of
// a row that releases results holds the input while right-border results pass through the cells.
// The vertical window is a chain of 2*MAX_RADIUS one-line delay cells, one block RAM each.
// Reset (rst_n low, synchronous) restores registers and counters; line RAMs are not cleared.
module dark_channel_min_filter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 15
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dcmf_pkg::APB_AW-1:0]      paddr,
  input  logic [dcmf_pkg::APB_DW-1:0]      pwdata,
  output logic [dcmf_pkg::APB_DW-1:0]      prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_req_type,
  input  logic [dcmf_pkg::PIX_W-1:0]       in_blue,
  input  logic [dcmf_pkg::PIX_W-1:0]       in_green,
  input  logic [dcmf_pkg::PIX_W-1:0]       in_red,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dcmf_pkg::PIX_W-1:0]       out_dark_value,
  output logic [dcmf_pkg::OUT_W-1:0]       out_out_row,
  output logic [dcmf_pkg::OUT_W-1:0]       out_out_col,
  output logic                             out_last_of_run,
  output logic                             out_frame_done
);
  import dcmf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int NV = 2 * MAX_RADIUS;
  localparam int NH = 2 * MAX_RADIUS + 1;
  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam int PW = $clog2(MAX_WIDTH + MAX_RADIUS);

  // configuration registers
  logic [DIM_W-1:0] width_r, height_r;
  logic [RAD_W-1:0] radius_r;
  logic             cfg_wr, cfg_hit;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  // only a write to an existing register restarts the frame
  assign cfg_hit = cfg_wr && ((paddr[3:2] == REG_WIDTH) || (paddr[3:2] == REG_HEIGHT) ||
                              (paddr[3:2] == REG_RADIUS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      radius_r <= RADIUS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        REG_RADIUS: radius_r <= pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      REG_RADIUS: prdata = 32'(radius_r);
      default:    prdata = '0;
    endcase
  end

  // effective frame geometry
  int unsigned w_i, h_i, r_i;
  always_comb begin
    if (width_r == '0) w_i = 1;
    else if (32'(width_r) > MAX_WIDTH) w_i = MAX_WIDTH;
    else w_i = 32'(width_r);
    if (height_r == '0) h_i = 1;
    else if (32'(height_r) > MAX_WIDTH) h_i = MAX_WIDTH;
    else h_i = 32'(height_r);
    if (32'(radius_r) > MAX_RADIUS) r_i = MAX_RADIUS;
    else r_i = 32'(radius_r);
  end

  // raster counters and right-border sequencer
  logic [ROW_W-1:0] ir_r, tail_row_r;
  logic [CW-1:0]    ic_r;
  logic [RW-1:0]    tail_cnt_r;
  logic [PW-1:0]    tail_pos_r;
  logic             adv, accept, drain, ignore, row_end, has_out, is_tail, tok_v;
  int unsigned      ir_i, ic_i, pos_i, o_i, c_i, r2_i;
  logic [PIX_W-1:0] pix_min, tok_data;
  logic [LIM_W-1:0] limv;
  meta_t            tok_meta;

  assign in_ready = adv && (tail_cnt_r == '0);
  assign accept   = in_valid && in_ready;

  always_comb begin
    ir_i    = 32'(ir_r);
    ic_i    = 32'(ic_r);
    r2_i    = 2 * r_i;
    drain   = ir_i >= h_i;
    ignore  = !drain && in_req_type;
    row_end = ic_i == w_i - 1;
    has_out = ir_i >= r_i;
    pix_min = min8(min8(in_blue, in_green), in_red);
    is_tail = tail_cnt_r != '0;
    if (is_tail) begin
      pos_i         = 32'(tail_pos_r);
      o_i           = 32'(tail_row_r);
      tok_v         = adv;
      tok_meta.last = tail_cnt_r == RW'(1);
    end else begin
      pos_i         = ic_i;
      o_i           = ir_i - r_i;
      tok_v         = accept && !ignore;
      tok_meta.last = !(row_end && r_i != 0);
    end
    c_i           = pos_i - r_i;
    tok_meta.emit = (pos_i >= r_i) && (is_tail || has_out);
    tok_meta.done = (o_i == h_i - 1) && (c_i == w_i - 1);
    tok_meta.hlim = (pos_i < r2_i) ? LIM_W'(pos_i) : LIM_W'(r2_i);
    tok_meta.orow = OUT_W'(o_i);
    tok_meta.ocol = OUT_W'(c_i);
    limv          = (ir_i < r2_i) ? LIM_W'(ir_i) : LIM_W'(r2_i);
    tok_data      = (is_tail || drain) ? PIX_MAX : pix_min;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      ir_r       <= '0;
      ic_r       <= '0;
      tail_cnt_r <= '0;
    end else begin
      if (is_tail && adv) begin
        tail_cnt_r <= tail_cnt_r - RW'(1);
        tail_pos_r <= tail_pos_r + PW'(1);
      end
      if (accept && !ignore) begin
        if (row_end) begin
          ic_r <= '0;
          if (ir_i + 1 >= h_i + r_i) ir_r <= '0;
          else ir_r <= ir_r + ROW_W'(1);
          if (has_out && r_i != 0) begin
            tail_cnt_r <= RW'(r_i);
            tail_pos_r <= PW'(w_i);
            tail_row_r <= ROW_W'(o_i);
          end
        end else begin
          ic_r <= ic_r + CW'(1);
        end
      end
    end
  end

  // vertical window: chain of one-line delay cells
  logic             st_v    [NV+1];
  logic             st_tail [NV+1];
  logic [CW-1:0]    st_addr [NV+1];
  logic [LIM_W-1:0] st_lim  [NV+1];
  meta_t            st_meta [NV+1];
  logic [PIX_W-1:0] st_run  [NV+1];
  logic [PIX_W-1:0] st_rd   [NV+1];
  logic             st_incl [NV+1];

  assign st_v[0]    = tok_v;
  assign st_tail[0] = is_tail;
  assign st_addr[0] = ic_r;
  assign st_lim[0]  = limv;
  assign st_meta[0] = tok_meta;
  assign st_run[0]  = tok_data;
  assign st_rd[0]   = tok_data;
  assign st_incl[0] = 1'b0;

  for (genvar k = 0; k < NV; k++) begin : g_cell
    dcmf_line_cell #(.DEPTH(MAX_WIDTH), .IDX(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_valid (st_v[k]),
      .in_tail  (st_tail[k]),
      .in_addr  (st_addr[k]),
      .in_lim   (st_lim[k]),
      .in_meta  (st_meta[k]),
      .in_run   (st_run[k]),
      .in_rd    (st_rd[k]),
      .in_incl  (st_incl[k]),
      .out_valid(st_v[k+1]),
      .out_tail (st_tail[k+1]),
      .out_addr (st_addr[k+1]),
      .out_lim  (st_lim[k+1]),
      .out_meta (st_meta[k+1]),
      .out_run  (st_run[k+1]),
      .out_rd   (st_rd[k+1]),
      .out_incl (st_incl[k+1])
    );
  end

  logic [PIX_W-1:0] vmin;
  assign vmin = st_incl[NV] ? min8(st_run[NV], st_rd[NV]) : st_run[NV];

  // horizontal window
  logic             hw_valid;
  logic [PIX_W-1:0] hw_dark;
  meta_t            hw_meta;

  dcmf_hwin #(.NH(NH)) u_hwin (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (st_v[NV]),
    .in_data  (vmin),
    .in_meta  (st_meta[NV]),
    .out_valid(hw_valid),
    .out_dark (hw_dark),
    .out_meta (hw_meta)
  );

  // two-entry result queue; pipeline moves whenever a slot is free
  res_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  res_t       q_out;

  assign adv  = cnt_r != 2'd2;
  assign push = adv && hw_valid;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{dark: hw_dark, orow: hw_meta.orow, ocol: hw_meta.ocol,
                     last: hw_meta.last, done: hw_meta.done};
    end
  end

  assign q_out           = q_r[rp_r];
  assign out_valid       = cnt_r != '0;
  assign out_dark_value  = q_out.dark;
  assign out_out_row     = q_out.orow;
  assign out_out_col     = q_out.ocol;
  assign out_last_of_run = q_out.last;
  assign out_frame_done  = q_out.done;

endmodule

[hw/rtl/dcmf_line_cell.sv]
module dcmf_line_cell #(
  parameter int DEPTH = 2048,
  parameter int IDX   = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic                          in_tail,
  input  logic [$clog2(DEPTH)-1:0]      in_addr,
  input  logic [dcmf_pkg::LIM_W-1:0]    in_lim,
  input  dcmf_pkg::meta_t               in_meta,
  input  logic [dcmf_pkg::PIX_W-1:0]    in_run,
  input  logic [dcmf_pkg::PIX_W-1:0]    in_rd,
  input  logic                          in_incl,
  output logic                          out_valid,
  output logic                          out_tail,
  output logic [$clog2(DEPTH)-1:0]      out_addr,
  output logic [dcmf_pkg::LIM_W-1:0]    out_lim,
  output dcmf_pkg::meta_t               out_meta,
  output logic [dcmf_pkg::PIX_W-1:0]    out_run,
  output logic [dcmf_pkg::PIX_W-1:0]    out_rd,
  output logic                          out_incl
);
  import dcmf_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] run_c;

  // fold the previous cell's row into the running column minimum
  assign run_c = in_incl ? min8(in_run, in_rd) : in_run;

  // one-line delay: read the older row, store the newer one
  always_ff @(posedge clk) begin
    if (adv && in_valid && !in_tail) begin
      out_rd        <= mem[in_addr];
      mem[in_addr]  <= in_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tail <= in_tail;
      out_addr <= in_addr;
      out_lim  <= in_lim;
      out_meta <= in_meta;
      out_run  <= run_c;
      out_incl <= in_valid && !in_tail && (32'(in_lim) >= IDX + 1);
    end
  end

endmodule

[hw/rtl/dcmf_hwin.sv]
module dcmf_hwin #(
  parameter int NH = 31
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [dcmf_pkg::PIX_W-1:0] in_data,
  input  dcmf_pkg::meta_t            in_meta,
  output logic                       out_valid,
  output logic [dcmf_pkg::PIX_W-1:0] out_dark,
  output dcmf_pkg::meta_t            out_meta
);
  import dcmf_pkg::*;

  localparam int NG = (NH + 7) / 8;

  logic [PIX_W-1:0] win_r [NH];
  logic             v1_r, v2_r;
  meta_t            meta1_r, meta2_r;
  logic [PIX_W-1:0] grp_nxt [NG];
  logic [PIX_W-1:0] grp_r   [NG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  // column minima shift in, newest at age zero
  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      win_r[0] <= in_data;
      for (int i = 1; i < NH; i++) win_r[i] <= win_r[i-1];
      meta1_r <= in_meta;
    end
  end

  // group minima over ages allowed by the left border
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = PIX_MAX;
      for (int j = 0; j < 8; j++) begin
        if ((g * 8 + j < NH) && (g * 8 + j <= 32'(meta1_r.hlim))) begin
          grp_nxt[g] = min8(grp_nxt[g], win_r[(g * 8 + j) % NH]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grp_r   <= grp_nxt;
      meta2_r <= meta1_r;
    end
  end

  // final reduction across groups
  always_comb begin
    out_dark = PIX_MAX;
    for (int g = 0; g < NG; g++) out_dark = min8(out_dark, grp_r[g]);
  end

  assign out_valid = v2_r && meta2_r.emit;
  assign out_meta  = meta2_r;

endmodule
